// ----- rtl/core/dss_pkg.sv -----
// ----------------------------------------------------------------------------
// dss_pkg
// Shared codes and the queued word descriptor for the display SPI serializer.
// ----------------------------------------------------------------------------
package dss_pkg;

  localparam int FUNC_W  = 3;
  localparam int VALUE_W = 16;
  localparam int FRAME_W = 18;   // two nine-bit frames
  localparam int CNT_W   = 5;

  localparam logic [FUNC_W-1:0] FUNC_BEGIN     = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_END       = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_CMD_BYTE  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_CMD_WORD  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DATA_BYTE = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_DATA_WORD = 3'd5;

  localparam logic CFG_THREE_WIRE = 1'b0;
  localparam logic CFG_CS_USED    = 1'b1;

  // one unit of work for the back end
  typedef struct packed {
    logic               is_ctrl;   // begin/end: one result, no clock pulse
    logic               cs_write;  // update chip select
    logic               cs_value;
    logic               dc_bit;    // DC level during serial bits
    logic [FRAME_W-1:0] bits;      // MSB-aligned bit pattern
    logic [CNT_W-1:0]   nbits_m1;  // bit count minus one
  } desc_t;

endpackage

// ----- rtl/core/dss_front.sv -----
// ----------------------------------------------------------------------------
// dss_front
// Holds the configuration; makes a descriptor of each accepted legal word.
// ----------------------------------------------------------------------------
module dss_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [dss_pkg::FUNC_W-1:0]  in_func,
  input  logic [dss_pkg::VALUE_W-1:0] in_value,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic                        cfg_wdata,
  input  logic                        q_full,
  output logic                        q_push,
  output dss_pkg::desc_t              q_desc
);

  logic three_wire_r, three_wire_nxt;
  logic cs_used_r, cs_used_nxt;
  logic legal;
  logic is_data;
  logic [7:0] byte_v;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  always_comb begin
    three_wire_nxt = three_wire_r;
    cs_used_nxt    = cs_used_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dss_pkg::CFG_THREE_WIRE: three_wire_nxt = cfg_wdata;
        dss_pkg::CFG_CS_USED:    cs_used_nxt    = cfg_wdata;
        default:                 three_wire_nxt = three_wire_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      three_wire_r <= 1'b0;
      cs_used_r    <= 1'b1;
    end else begin
      three_wire_r <= three_wire_nxt;
      cs_used_r    <= cs_used_nxt;
    end
  end

  assign byte_v  = in_value[7:0];
  assign is_data = (in_func == dss_pkg::FUNC_DATA_BYTE) ||
                   (in_func == dss_pkg::FUNC_DATA_WORD);

  always_comb begin
    legal           = 1'b1;
    q_desc.is_ctrl  = 1'b0;
    q_desc.cs_write = 1'b0;
    q_desc.cs_value = 1'b1;
    q_desc.dc_bit   = three_wire_r | is_data;
    q_desc.bits     = '0;
    q_desc.nbits_m1 = '0;
    case (in_func)
      dss_pkg::FUNC_BEGIN: begin
        q_desc.is_ctrl  = 1'b1;
        q_desc.cs_write = cs_used_r;
        q_desc.cs_value = 1'b0;
      end
      dss_pkg::FUNC_END: begin
        q_desc.is_ctrl  = 1'b1;
        q_desc.cs_write = cs_used_r;
        q_desc.cs_value = 1'b1;
      end
      dss_pkg::FUNC_CMD_BYTE, dss_pkg::FUNC_DATA_BYTE: begin
        if (three_wire_r) begin
          q_desc.bits     = {is_data, byte_v, 9'b0};
          q_desc.nbits_m1 = 5'd8;
        end else begin
          q_desc.bits     = {byte_v, 10'b0};
          q_desc.nbits_m1 = 5'd7;
        end
      end
      dss_pkg::FUNC_CMD_WORD, dss_pkg::FUNC_DATA_WORD: begin
        if (three_wire_r) begin
          // high byte frame first
          q_desc.bits     = {is_data, in_value[15:8], is_data, in_value[7:0]};
          q_desc.nbits_m1 = 5'd17;
        end else begin
          q_desc.bits     = {in_value, 2'b0};
          q_desc.nbits_m1 = 5'd15;
        end
      end
      default: legal = 1'b0;  // drop unused codes
    endcase
  end

  assign q_push = in_valid && !in_stall && legal;

endmodule

// ----- rtl/core/dss_fifo.sv -----
// ----------------------------------------------------------------------------
// dss_fifo
// Short descriptor queue between the front and back ends.
// ----------------------------------------------------------------------------
module dss_fifo #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dss_pkg::desc_t push_desc,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output dss_pkg::desc_t q_desc
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  dss_pkg::desc_t entry_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign full    = (count_r == CW'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_desc  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

// ----- rtl/core/dss_back.sv -----
// ----------------------------------------------------------------------------
// dss_back
// Shifts out one bit per cycle unless stalled; drives the pin-level results.
// ----------------------------------------------------------------------------
module dss_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  dss_pkg::desc_t q_desc,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           out_mosi_level,
  output logic           out_dc_level,
  output logic           out_cs_level,
  output logic           out_clock_pulse,
  output logic           out_last
);

  logic                        act_r, act_nxt;
  logic                        ctrl_r, ctrl_nxt;
  logic                        cs_write_r, cs_write_nxt;
  logic                        cs_value_r, cs_value_nxt;
  logic                        dc_r, dc_nxt;
  logic [dss_pkg::FRAME_W-1:0] sh_r, sh_nxt;
  logic [dss_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                        cs_r, cs_nxt;
  logic                        mosi_r, mosi_nxt;

  logic out_valid_r, out_valid_nxt;
  logic o_mosi_r, o_mosi_nxt;
  logic o_dc_r, o_dc_nxt;
  logic o_cs_r, o_cs_nxt;
  logic o_clk_r, o_clk_nxt;
  logic o_last_r, o_last_nxt;

  logic out_free, emit, last_now, cs_new;

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = act_r && out_free;
  assign last_now = ctrl_r || (cnt_r == '0);
  assign cs_new   = cs_write_r ? cs_value_r : cs_r;
  assign q_pop    = q_valid && (!act_r || (emit && last_now));

  always_comb begin
    act_nxt       = act_r;
    ctrl_nxt      = ctrl_r;
    cs_write_nxt  = cs_write_r;
    cs_value_nxt  = cs_value_r;
    dc_nxt        = dc_r;
    sh_nxt        = sh_r;
    cnt_nxt       = cnt_r;
    cs_nxt        = cs_r;
    mosi_nxt      = mosi_r;
    out_valid_nxt = out_valid_r && out_stall;
    o_mosi_nxt    = o_mosi_r;
    o_dc_nxt      = o_dc_r;
    o_cs_nxt      = o_cs_r;
    o_clk_nxt     = o_clk_r;
    o_last_nxt    = o_last_r;

    if (emit) begin
      out_valid_nxt = 1'b1;
      o_last_nxt    = last_now;
      if (ctrl_r) begin
        // begin/end report the lines after the update
        cs_nxt     = cs_new;
        o_mosi_nxt = mosi_r;
        o_dc_nxt   = 1'b1;
        o_cs_nxt   = cs_new;
        o_clk_nxt  = 1'b0;
      end else begin
        mosi_nxt   = sh_r[dss_pkg::FRAME_W-1];
        sh_nxt     = {sh_r[dss_pkg::FRAME_W-2:0], 1'b0};
        cnt_nxt    = cnt_r - 1'b1;
        o_mosi_nxt = sh_r[dss_pkg::FRAME_W-1];
        o_dc_nxt   = dc_r;
        o_cs_nxt   = cs_r;
        o_clk_nxt  = 1'b1;
      end
      if (last_now) begin
        act_nxt = 1'b0;
      end
    end

    if (q_pop) begin
      act_nxt      = 1'b1;
      ctrl_nxt     = q_desc.is_ctrl;
      cs_write_nxt = q_desc.cs_write;
      cs_value_nxt = q_desc.cs_value;
      dc_nxt       = q_desc.dc_bit;
      sh_nxt       = q_desc.bits;
      cnt_nxt      = q_desc.nbits_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      cs_r        <= 1'b1;
      mosi_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      act_r       <= act_nxt;
      cs_r        <= cs_nxt;
      mosi_r      <= mosi_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctrl_r     <= ctrl_nxt;
    cs_write_r <= cs_write_nxt;
    cs_value_r <= cs_value_nxt;
    dc_r       <= dc_nxt;
    sh_r       <= sh_nxt;
    cnt_r      <= cnt_nxt;
    o_mosi_r   <= o_mosi_nxt;
    o_dc_r     <= o_dc_nxt;
    o_cs_r     <= o_cs_nxt;
    o_clk_r    <= o_clk_nxt;
    o_last_r   <= o_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_mosi_level  = o_mosi_r;
  assign out_dc_level    = o_dc_r;
  assign out_cs_level    = o_cs_r;
  assign out_clock_pulse = o_clk_r;
  assign out_last        = o_last_r;

endmodule

// ----- rtl/core/display_spi_serializer_core.sv -----
// ----------------------------------------------------------------------------
// display_spi_serializer_core
// Write-only SPI bit serializer for a display controller (3-wire or 4-wire).
// ----------------------------------------------------------------------------
// Each input word is decoded by the front end into a descriptor and queued
// (QUEUE_DEPTH entries); the back end's shift register then emits one result
// per clock while the output is not stalled: one result for begin/end, 8 or 9
// for a byte and 16 or 18 for a word (four-wire / three-wire). Results flow back
// to back across words as long as the output is not stalled, and new words are
// taken while the queue has room. Function codes 6 and 7 are accepted and
// dropped. The configuration takes effect for words accepted after the write.
module display_spi_serializer_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [dss_pkg::FUNC_W-1:0]  in_func,
  input  logic [dss_pkg::VALUE_W-1:0] in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_mosi_level,
  output logic                        out_dc_level,
  output logic                        out_cs_level,
  output logic                        out_clock_pulse,
  output logic                        out_last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic                        cfg_wdata
);

  logic           q_full, q_push, q_pop, q_valid;
  dss_pkg::desc_t push_desc, head_desc;

  dss_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_func   (in_func),
    .in_value  (in_value),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_desc    (push_desc)
  );

  dss_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_desc    (head_desc)
  );

  dss_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_desc          (head_desc),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_mosi_level  (out_mosi_level),
    .out_dc_level    (out_dc_level),
    .out_cs_level    (out_cs_level),
    .out_clock_pulse (out_clock_pulse),
    .out_last        (out_last)
  );

endmodule

// ----- rtl/core/dss_checker.sv -----
// ----------------------------------------------------------------------------
// dss_checker
// Port-level checks for the display SPI serializer, bound to the top level.
// ----------------------------------------------------------------------------
module dss_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input logic out_dc_level,
  input logic out_clock_pulse,
  input logic out_last
);

  // a stalled result must stay presented
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // begin/end give exactly one result
  a_ctrl_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_clock_pulse |-> out_last)
    else $error("control result not marked last");

  // DC is high on begin/end results
  a_ctrl_dc_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_clock_pulse |-> out_dc_level)
    else $error("DC low on control result");

endmodule

bind display_spi_serializer_core dss_checker u_dss_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_dc_level    (out_dc_level),
  .out_clock_pulse (out_clock_pulse),
  .out_last        (out_last)
);

// ----- verif/display_spi_serializer_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_spi_serializer_core_tb
// Checks the serializer pin stream against a cycle-free line model.
// Directed words cover every function code and both wire modes with and
// without chip select. Random transfers follow, with idle gaps on the input
// and stalls on the output, and settings changed between drained phases.
// ----------------------------------------------------------------------------
module display_spi_serializer_core_tb;

  localparam int DRAIN_CYCLES = 48;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 440;

  // function codes the block ignores
  localparam logic [dss_pkg::FUNC_W-1:0] FUNC_UNUSED_LO = 3'd6;
  localparam logic [dss_pkg::FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [dss_pkg::FUNC_W-1:0]  func;
    logic [dss_pkg::VALUE_W-1:0] value;
  } op_t;

  typedef struct packed {
    logic mosi;
    logic dc;
    logic cs;
    logic pulse;
    logic last;
  } pin_state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [dss_pkg::FUNC_W-1:0] in_func = '0;
  logic [dss_pkg::VALUE_W-1:0] in_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_mosi_level;
  logic out_dc_level;
  logic out_cs_level;
  logic out_clock_pulse;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic cfg_wdata = 1'b0;

  display_spi_serializer_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_mosi_level  (out_mosi_level),
    .out_dc_level    (out_dc_level),
    .out_cs_level    (out_cs_level),
    .out_clock_pulse (out_clock_pulse),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  op_t        pending_ops[$];
  pin_state_t expected_pins[$];

  // line model state and settings
  logic three_wire = 1'b0;
  logic cs_driven = 1'b1;
  logic cs_q = 1'b1;
  logic dc_q = 1'b1;
  logic mosi_q = 1'b0;

  int mismatches = 0;
  int stim_items = 0;
  int calm_in = 0;
  int calm_out = 0;
  int gap_left = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int pick_pause(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // shift out the low n bits MSB first, one pin state per bit
  function automatic void shift_pins(logic [dss_pkg::FRAME_W-1:0] bits, int n,
                                     logic dc_during);
    for (int i = n - 1; i >= 0; i--) begin
      mosi_q = bits[i];
      expected_pins.push_back('{mosi_q, dc_during, cs_q, 1'b1, i == 0});
    end
  endfunction

  function automatic void predict_pins(op_t op);
    logic is_data;
    logic [7:0] hi;
    logic [7:0] lo;
    is_data = (op.func == dss_pkg::FUNC_DATA_BYTE) || (op.func == dss_pkg::FUNC_DATA_WORD);
    hi = op.value[15:8];
    lo = op.value[7:0];
    case (op.func)
      dss_pkg::FUNC_BEGIN: begin
        if (!three_wire) dc_q = 1'b1;
        if (cs_driven) cs_q = 1'b0;
        expected_pins.push_back('{mosi_q, dc_q, cs_q, 1'b0, 1'b1});
      end
      dss_pkg::FUNC_END: begin
        if (cs_driven) cs_q = 1'b1;
        expected_pins.push_back('{mosi_q, dc_q, cs_q, 1'b0, 1'b1});
      end
      dss_pkg::FUNC_CMD_BYTE, dss_pkg::FUNC_DATA_BYTE: begin
        if (three_wire) begin
          shift_pins({9'd0, is_data, lo}, 9, dc_q);
        end else begin
          shift_pins({10'd0, lo}, 8, is_data);
          dc_q = 1'b1;
        end
      end
      dss_pkg::FUNC_CMD_WORD, dss_pkg::FUNC_DATA_WORD: begin
        if (three_wire) begin
          shift_pins({is_data, hi, is_data, lo}, 18, dc_q);
        end else begin
          shift_pins({2'd0, op.value}, 16, is_data);
          dc_q = 1'b1;
        end
      end
      default: begin
        // unused codes: drop
      end
    endcase
  endfunction

  // driver
  always @(posedge clk) begin : driver
    op_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) predict_pins('{in_func, in_value});
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          nxt = pending_ops.pop_front();
          in_valid <= 1'b1;
          in_func <= nxt.func;
          in_value <= nxt.value;
          gap_left = pick_pause(calm_in);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    pin_state_t want;
    pin_state_t got;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_mosi_level, out_dc_level, out_cs_level, out_clock_pulse,
                out_last};
        if (expected_pins.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected word: mosi=%0b dc=%0b cs=%0b pulse=%0b last=%0b",
                     got.mosi, got.dc, got.cs, got.pulse, got.last);
          mismatches++;
        end else begin
          want = expected_pins.pop_front();
          if (got.mosi !== want.mosi || got.dc !== want.dc || got.cs !== want.cs ||
              got.pulse !== want.pulse || got.last !== want.last) begin
            if (mismatches < 10)
              $display({"mismatch: exp mosi=%0b dc=%0b cs=%0b pulse=%0b last=%0b,",
                        " got mosi=%0b dc=%0b cs=%0b pulse=%0b last=%0b"},
                       want.mosi, want.dc, want.cs, want.pulse, want.last,
                       got.mosi, got.dc, got.cs, got.pulse, got.last);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = pick_pause(calm_out);
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: abort when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_op(logic [dss_pkg::FUNC_W-1:0] f, logic [dss_pkg::VALUE_W-1:0] v);
    pending_ops.push_back('{f, v});
    if (f <= dss_pkg::FUNC_DATA_WORD) stim_items++;
  endtask

  function automatic logic [dss_pkg::VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return dss_pkg::VALUE_W'($urandom);
  endfunction

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_ops.size() != 0 || in_valid || expected_pins.size() != 0);
  endtask

  task automatic settle();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == dss_pkg::CFG_THREE_WIRE) three_wire = val;
    else cs_driven = val;
  endtask

  // mostly well-formed transfers, some loose words and unused codes
  task automatic make_traffic(int count);
    int target;
    int n_data;
    logic [dss_pkg::FUNC_W-1:0] f;
    target = stim_items + count;
    while (stim_items < target) begin
      if ($urandom_range(0, 9) < 8) begin
        push_op(dss_pkg::FUNC_BEGIN, pick_value());
        push_op($urandom_range(0, 1) ? dss_pkg::FUNC_CMD_WORD : dss_pkg::FUNC_CMD_BYTE,
                pick_value());
        n_data = $urandom_range(0, 6);
        for (int i = 0; i < n_data; i++) begin
          f = $urandom_range(0, 3) == 0 ? dss_pkg::FUNC_CMD_BYTE :
              ($urandom_range(0, 1) ? dss_pkg::FUNC_DATA_WORD : dss_pkg::FUNC_DATA_BYTE);
          push_op(f, pick_value());
        end
        if ($urandom_range(0, 7) != 0) push_op(dss_pkg::FUNC_END, pick_value());
      end else begin
        push_op(dss_pkg::FUNC_W'($urandom_range(0, 7)), pick_value());
      end
    end
  endtask

  task automatic run_phase(logic tw, logic csu, int count);
    write_reg(dss_pkg::CFG_THREE_WIRE, tw);
    write_reg(dss_pkg::CFG_CS_USED, csu);
    make_traffic(count / 2);
    // hold the input until the pins catch up
    wait_drained();
    make_traffic(count - count / 2);
    settle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // four-wire, chip select used (reset settings)
    push_op(dss_pkg::FUNC_BEGIN, 16'h0000);
    push_op(dss_pkg::FUNC_CMD_BYTE, 16'h002A);
    push_op(dss_pkg::FUNC_CMD_WORD, 16'h0000);
    push_op(dss_pkg::FUNC_CMD_WORD, 16'hFFFF);
    push_op(dss_pkg::FUNC_DATA_BYTE, 16'hFF00);
    push_op(dss_pkg::FUNC_DATA_BYTE, 16'h00FF);
    push_op(dss_pkg::FUNC_DATA_WORD, 16'h8001);
    push_op(FUNC_UNUSED_LO, 16'hFFFF);
    push_op(FUNC_UNUSED_HI, 16'h5A5A);
    push_op(dss_pkg::FUNC_END, 16'hFFFF);
    settle();

    // three-wire frames
    write_reg(dss_pkg::CFG_THREE_WIRE, 1'b1);
    push_op(dss_pkg::FUNC_BEGIN, 16'hFFFF);
    push_op(dss_pkg::FUNC_CMD_BYTE, 16'hC33C);
    push_op(dss_pkg::FUNC_DATA_BYTE, 16'h00FF);
    push_op(dss_pkg::FUNC_CMD_WORD, 16'h1234);
    push_op(dss_pkg::FUNC_DATA_WORD, 16'hFFFF);
    push_op(dss_pkg::FUNC_DATA_WORD, 16'h0000);
    settle();

    // leave chip select low, then stop driving it
    write_reg(dss_pkg::CFG_CS_USED, 1'b0);
    push_op(dss_pkg::FUNC_DATA_BYTE, 16'h00A5);
    push_op(dss_pkg::FUNC_END, 16'h0000);
    push_op(dss_pkg::FUNC_BEGIN, 16'h0000);
    settle();

    // back to four-wire with held lines
    write_reg(dss_pkg::CFG_THREE_WIRE, 1'b0);
    push_op(dss_pkg::FUNC_CMD_BYTE, 16'h00FF);
    push_op(dss_pkg::FUNC_DATA_BYTE, 16'h0080);
    push_op(dss_pkg::FUNC_END, 16'h0000);
    settle();

    run_phase(1'b0, 1'b1, RANDOM_ITEMS / 6);
    run_phase(1'b1, 1'b1, RANDOM_ITEMS / 6);
    run_phase(1'b0, 1'b0, RANDOM_ITEMS / 6);
    run_phase(1'b1, 1'b0, RANDOM_ITEMS / 6);
    run_phase($urandom_range(0, 1), 1'b1, RANDOM_ITEMS / 6);
    run_phase($urandom_range(0, 1), $urandom_range(0, 1), RANDOM_ITEMS / 6);

    if (mismatches == 0 && expected_pins.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
